// ----- rtl/aft_pkg.sv -----
// ----------------------------------------------------------------------------
// aft_pkg
// Shared types, widths and codes of the animation frame timer.
// ----------------------------------------------------------------------------
package aft_pkg;

    localparam int MAX_FRAMES_DEF = 256;
    localparam int DELAY_W        = 20;
    localparam int TEX_W          = 32;
    localparam int TIME_W         = 32;
    localparam int IDX_W          = 8;
    localparam int TOTAL_W        = 9;
    localparam int SUM_W          = DELAY_W + TOTAL_W;
    localparam int DIV_CNT_W      = 5;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [DELAY_W-1:0] MIN_DELAY_MS = DELAY_W'(10);

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    typedef enum logic {
        REG_ENABLE      = 1'b0,
        REG_FRAME_TOTAL = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CUR,
        S_SUM,
        S_DIV,
        S_ADV
    } state_t;

    typedef struct packed {
        func_t               func;
        logic [IDX_W-1:0]    entry_index;
        logic [DELAY_W-1:0]  entry_delay_ms;
        logic [TEX_W-1:0]    entry_texture;
        logic [TIME_W-1:0]   now_ms;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]    frame_index;
        logic [TEX_W-1:0]    texture_out;
        logic                changed;
    } result_t;

    function automatic logic [DELAY_W-1:0] clamp_delay(logic [DELAY_W-1:0] d);
        return (d < MIN_DELAY_MS) ? MIN_DELAY_MS : d;
    endfunction

endpackage

// ----- rtl/animation_frame_timer.sv -----
// ----------------------------------------------------------------------------
// animation_frame_timer
// Frame timeline of a looping animation held in delay and texture tables.
// Load beat, or tick that is ignored or only records the time: result beat
// valid in the cycle after acceptance. Tick inside the current delay: result
// after the current delay read in S_CUR. Full tick: current delay read, N reads
// of the delay table for the loop sum, 32 remainder steps, up to N advance steps.
// One beat in flight at a time; the next is accepted once the result leaves.
// Reset clears frame, time, texture and configuration; tables are unset.
// ----------------------------------------------------------------------------
module animation_frame_timer #(
    parameter int MAX_FRAMES = aft_pkg::MAX_FRAMES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  aft_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output aft_pkg::result_t              result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aft_pkg::PADDR_W-1:0]   paddr,
    input  logic [aft_pkg::PDATA_W-1:0]   pwdata,
    output logic [aft_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int IW = $clog2(MAX_FRAMES);
    localparam int NW = (IW + 1 > aft_pkg::TOTAL_W) ? IW + 1 : aft_pkg::TOTAL_W;

    function automatic logic [IW-1:0] next_frame(logic [IW-1:0] f,
                                                 logic [aft_pkg::TOTAL_W-1:0] c);
        logic [NW-1:0] s;
        s = NW'(f) + NW'(1);
        return (s == NW'(c)) ? '0 : IW'(s);
    endfunction

    logic [aft_pkg::DELAY_W-1:0] delay_mem [MAX_FRAMES];
    logic [aft_pkg::TEX_W-1:0]   tex_mem   [MAX_FRAMES];

    aft_pkg::state_t               state_reg, state_next;
    logic [IW-1:0]                 shown_reg, shown_next;
    logic [aft_pkg::TEX_W-1:0]     texture_reg, texture_next;
    logic [aft_pkg::TIME_W-1:0]    last_reg, last_next;
    logic                          seen_reg, seen_next;
    logic                          enable_reg;
    logic [aft_pkg::TOTAL_W-1:0]   total_reg;
    logic [aft_pkg::TIME_W-1:0]    now_reg, now_next;
    logic [aft_pkg::TIME_W-1:0]    rem_reg, rem_next;
    logic [aft_pkg::SUM_W-1:0]     acc_reg, acc_next;
    logic [aft_pkg::SUM_W-1:0]     cycle_reg, cycle_next;
    logic [aft_pkg::TOTAL_W-1:0]   idx_reg, idx_next;
    logic [aft_pkg::TIME_W-1:0]    dvd_reg, dvd_next;
    logic [aft_pkg::SUM_W-1:0]     r_reg, r_next;
    logic [aft_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          changed_reg, changed_next;
    logic                          out_valid_reg, out_valid_next;
    aft_pkg::result_t              out_reg, out_next;

    logic [aft_pkg::DELAY_W-1:0]   rd_delay_reg;
    logic [aft_pkg::TEX_W-1:0]     rd_tex_reg;
    logic [IW-1:0]                 rd_addr_d, rd_addr_t;
    logic                          wr_en;
    logic [IW-1:0]                 wr_addr;

    logic [aft_pkg::TOTAL_W-1:0]   count;
    logic                          accept;
    logic                          emit;
    logic [IW-1:0]                 fix_frame;
    logic [IW-1:0]                 nf;
    logic [aft_pkg::DELAY_W-1:0]   dly;
    logic [aft_pkg::SUM_W-1:0]     acc_sum;
    logic [aft_pkg::SUM_W:0]       r_shift;
    logic [aft_pkg::SUM_W-1:0]     r_new;
    logic                          cfg_wr;

    assign count = (32'(total_reg) > MAX_FRAMES) ? aft_pkg::TOTAL_W'(MAX_FRAMES) : total_reg;
    assign item_stall   = (state_reg != aft_pkg::S_IDLE) || (out_valid_reg && result_stall);
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign pready       = 1'b1;
    assign cfg_wr       = psel && penable && pwrite && pready;
    assign fix_frame    = (NW'(shown_reg) >= NW'(count)) ? '0 : shown_reg;
    assign nf           = next_frame(shown_reg, count);
    assign dly          = aft_pkg::clamp_delay(rd_delay_reg);

    always_comb
    begin
        case (aft_pkg::reg_idx_t'(paddr[2]))
            aft_pkg::REG_ENABLE:      prdata = aft_pkg::PDATA_W'(enable_reg);
            aft_pkg::REG_FRAME_TOTAL: prdata = aft_pkg::PDATA_W'(total_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            total_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (aft_pkg::reg_idx_t'(paddr[2]))
                aft_pkg::REG_ENABLE:      enable_reg <= pwdata[0];
                aft_pkg::REG_FRAME_TOTAL: total_reg  <= pwdata[aft_pkg::TOTAL_W-1:0];
                default:                  enable_reg <= enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            delay_mem[wr_addr] <= item.entry_delay_ms;
            tex_mem[wr_addr]   <= item.entry_texture;
        end
        rd_delay_reg <= delay_mem[rd_addr_d];
        rd_tex_reg   <= tex_mem[rd_addr_t];
    end

    always_comb
    begin
        state_next     = state_reg;
        shown_next     = shown_reg;
        texture_next   = texture_reg;
        last_next      = last_reg;
        seen_next      = seen_reg;
        now_next       = now_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        cycle_next     = cycle_reg;
        idx_next       = idx_reg;
        dvd_next       = dvd_reg;
        r_next         = r_reg;
        cnt_next       = cnt_reg;
        changed_next   = changed_reg;
        out_valid_next = out_valid_reg && result_stall;
        rd_addr_d      = '0;
        rd_addr_t      = '0;
        wr_en          = 1'b0;
        wr_addr        = IW'(item.entry_index);
        emit           = 1'b0;
        acc_sum        = acc_reg + aft_pkg::SUM_W'(dly);
        r_shift        = {r_reg, dvd_reg[aft_pkg::TIME_W-1]};
        r_new          = (r_shift >= {1'b0, cycle_reg})
                         ? aft_pkg::SUM_W'(r_shift - {1'b0, cycle_reg})
                         : aft_pkg::SUM_W'(r_shift);

        case (state_reg)
            aft_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    changed_next = 1'b0;
                    case (item.func)
                        aft_pkg::FUNC_LOAD:
                        begin
                            wr_en = (32'(item.entry_index) < MAX_FRAMES);
                            emit  = 1'b1;
                        end
                        aft_pkg::FUNC_TICK:
                        begin
                            if (!enable_reg || count <= aft_pkg::TOTAL_W'(1))
                            begin
                                emit = 1'b1;
                            end
                            else if (!seen_reg || item.now_ms < last_reg)
                            begin
                                last_next = item.now_ms;
                                seen_next = 1'b1;
                                emit      = 1'b1;
                            end
                            else
                            begin
                                shown_next = fix_frame;
                                now_next   = item.now_ms;
                                rem_next   = item.now_ms - last_reg;
                                rd_addr_d  = fix_frame;
                                state_next = aft_pkg::S_CUR;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            aft_pkg::S_CUR:
            begin
                if (rem_reg < aft_pkg::TIME_W'(dly))
                begin
                    emit       = 1'b1;
                    state_next = aft_pkg::S_IDLE;
                end
                else
                begin
                    rd_addr_d  = '0;
                    idx_next   = aft_pkg::TOTAL_W'(1);
                    acc_next   = '0;
                    state_next = aft_pkg::S_SUM;
                end
            end
            aft_pkg::S_SUM:
            begin
                if (idx_reg == count)
                begin
                    cycle_next = acc_sum;
                    dvd_next   = rem_reg;
                    r_next     = '0;
                    cnt_next   = '1;
                    state_next = aft_pkg::S_DIV;
                end
                else
                begin
                    rd_addr_d = IW'(idx_reg);
                    idx_next  = idx_reg + aft_pkg::TOTAL_W'(1);
                    acc_next  = acc_sum;
                end
            end
            aft_pkg::S_DIV:
            begin
                r_next   = r_new;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - aft_pkg::DIV_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    rem_next   = aft_pkg::TIME_W'(r_new);
                    rd_addr_d  = shown_reg;
                    rd_addr_t  = nf;
                    idx_next   = '0;
                    state_next = aft_pkg::S_ADV;
                end
            end
            aft_pkg::S_ADV:
            begin
                if (rem_reg < aft_pkg::TIME_W'(dly))
                begin
                    last_next  = now_reg - rem_reg;
                    emit       = 1'b1;
                    state_next = aft_pkg::S_IDLE;
                end
                else
                begin
                    shown_next   = nf;
                    texture_next = rd_tex_reg;
                    rem_next     = rem_reg - aft_pkg::TIME_W'(dly);
                    changed_next = 1'b1;
                    idx_next     = idx_reg + aft_pkg::TOTAL_W'(1);
                    if (idx_next == count)
                    begin
                        last_next  = now_reg - rem_next;
                        emit       = 1'b1;
                        state_next = aft_pkg::S_IDLE;
                    end
                    else
                    begin
                        rd_addr_d = nf;
                        rd_addr_t = next_frame(nf, count);
                    end
                end
            end
            default:
            begin
                state_next = aft_pkg::S_IDLE;
            end
        endcase

        out_next = out_reg;
        if (emit)
        begin
            out_valid_next       = 1'b1;
            out_next.frame_index = aft_pkg::IDX_W'(shown_next);
            out_next.texture_out = texture_next;
            out_next.changed     = changed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aft_pkg::S_IDLE;
            shown_reg     <= '0;
            texture_reg   <= '0;
            last_reg      <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            changed_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shown_reg     <= shown_next;
            texture_reg   <= texture_next;
            last_reg      <= last_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            changed_reg   <= changed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg   <= now_next;
        rem_reg   <= rem_next;
        acc_reg   <= acc_next;
        cycle_reg <= cycle_next;
        dvd_reg   <= dvd_next;
        r_reg     <= r_next;
        out_reg   <= out_next;
    end

endmodule

// ----- rtl/aft_checker.sv -----
// ----------------------------------------------------------------------------
// aft_checker
// Port-level checks of the animation frame timer, bound to the top level.
// ----------------------------------------------------------------------------
module aft_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          item_stall,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  aft_pkg::result_t              result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aft_pkg::PADDR_W-1:0]   paddr,
    input  logic [aft_pkg::PDATA_W-1:0]   pwdata,
    input  logic                          pready
);

    logic                        en_reg;
    logic [aft_pkg::TOTAL_W-1:0] total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= 1'b0;
            total_reg <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (aft_pkg::reg_idx_t'(paddr[2]))
                aft_pkg::REG_ENABLE:      en_reg    <= pwdata[0];
                aft_pkg::REG_FRAME_TOTAL: total_reg <= pwdata[aft_pkg::TOTAL_W-1:0];
                default:                  en_reg    <= en_reg;
            endcase
        end
    end

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

    a_accept_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |-> !(result_valid && result_stall))
        else $error("beat accepted while result slot held");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result beat changed");

    a_changed_needs_anim: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.changed) |-> (en_reg && total_reg > aft_pkg::TOTAL_W'(1)))
        else $error("frame advanced without an enabled multi-frame animation");

endmodule

bind animation_frame_timer aft_checker u_aft_checker (.*);

// ----- dv/tb_animation_frame_timer.sv -----
// ----------------------------------------------------------------------------
// tb_animation_frame_timer
// Self-checking bench for the animation frame timer. Load and tick beats go
// through a bursty driver. A clocked monitor compares every result beat with
// a timeline predictor kept inside the bench. The APB port steps the enable
// and frame total through a series of settings, including the extremes.
// ----------------------------------------------------------------------------
module tb_animation_frame_timer;

    localparam int                          FRAME_SLOTS  = 256;
    localparam logic [aft_pkg::DELAY_W-1:0] MIN_FRAME_MS = aft_pkg::DELAY_W'(10);

    logic                         clk;
    logic                         rst_n        = 1'b0;
    logic                         item_valid   = 1'b0;
    logic                         item_stall;
    aft_pkg::item_t               item         = '0;
    logic                         result_valid;
    logic                         result_stall = 1'b0;
    aft_pkg::result_t             result;
    logic                         psel         = 1'b0;
    logic                         penable      = 1'b0;
    logic                         pwrite       = 1'b0;
    logic [aft_pkg::PADDR_W-1:0]  paddr        = '0;
    logic [aft_pkg::PDATA_W-1:0]  pwdata       = '0;
    logic [aft_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    animation_frame_timer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    aft_pkg::item_t               pending_beats[$];
    aft_pkg::result_t             expected_frames[$];
    aft_pkg::result_t             accepted_frame;
    aft_pkg::result_t             want_frame;

    logic [aft_pkg::DELAY_W-1:0]  delay_mem [FRAME_SLOTS];
    logic [aft_pkg::TEX_W-1:0]    tex_mem   [FRAME_SLOTS];
    bit                           loaded    [FRAME_SLOTS];
    int                           cur_frame  = 0;
    logic [aft_pkg::TEX_W-1:0]    cur_tex    = '0;
    logic [aft_pkg::TIME_W-1:0]   last_ms    = '0;
    bit                           time_known = 1'b0;
    bit                           cfg_enable = 1'b0;
    int                           cfg_total  = 0;

    logic [aft_pkg::TIME_W-1:0]   gen_now    = '0;
    int                           burst_left = 0;
    int                           gap_left   = 0;
    int                           stall_mode = 0;
    int                           mode_left  = 0;
    int                           stall_tick = 0;

    int                           fail_count    = 0;
    int                           load_beats    = 0;
    int                           tick_beats    = 0;
    int                           frames_moved  = 0;
    int                           loop_skips    = 0;
    int                           settings_used = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #80_000_000;
        $display("Timed out with %0d results outstanding", expected_frames.size());
        $display("animation_frame_timer test failed");
        $finish;
    end

    function automatic logic [aft_pkg::DELAY_W-1:0] floor_delay(
        input logic [aft_pkg::DELAY_W-1:0] d);
        return (d < MIN_FRAME_MS) ? MIN_FRAME_MS : d;
    endfunction

    task automatic step_timeline(input aft_pkg::item_t beat, output aft_pkg::result_t res);
        int                          count;
        int                          steps;
        logic [aft_pkg::TIME_W-1:0]  elapsed;
        logic [63:0]                 loop_ms;
        logic [aft_pkg::DELAY_W-1:0] d;
        bit                          moved;
        bit                          halt;
        moved = 1'b0;
        if (beat.func == aft_pkg::FUNC_LOAD)
        begin
            delay_mem[beat.entry_index] = beat.entry_delay_ms;
            tex_mem[beat.entry_index]   = beat.entry_texture;
        end
        else
        begin
            count = (cfg_total > FRAME_SLOTS) ? FRAME_SLOTS : cfg_total;
            if (cfg_enable && count > 1)
            begin
                if (!time_known || beat.now_ms < last_ms)
                begin
                    last_ms    = beat.now_ms;
                    time_known = 1'b1;
                end
                else
                begin
                    if (cur_frame >= count)
                        cur_frame = 0;
                    elapsed = beat.now_ms - last_ms;
                    if (elapsed >= floor_delay(delay_mem[cur_frame]))
                    begin
                        loop_ms = '0;
                        for (int n = 0; n < count; n++)
                            loop_ms += floor_delay(delay_mem[n]);
                        if (64'(elapsed) >= loop_ms)
                        begin
                            last_ms = last_ms + 32'((64'(elapsed) / loop_ms) * loop_ms);
                            loop_skips++;
                        end
                        steps = 0;
                        halt  = 1'b0;
                        while (steps < count && !halt)
                        begin
                            d = floor_delay(delay_mem[cur_frame]);
                            if (32'(beat.now_ms - last_ms) < 32'(d))
                                halt = 1'b1;
                            else
                            begin
                                cur_frame = (cur_frame + 1) % count;
                                cur_tex   = tex_mem[cur_frame];
                                last_ms   = last_ms + 32'(d);
                                moved     = 1'b1;
                                steps++;
                            end
                        end
                    end
                end
            end
        end
        res.frame_index = aft_pkg::IDX_W'(cur_frame);
        res.texture_out = cur_tex;
        res.changed     = moved;
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                step_timeline(item, accepted_frame);
                expected_frames.push_back(accepted_frame);
                if (item.func == aft_pkg::FUNC_LOAD)
                    load_beats++;
                else
                    tick_beats++;
            end
            if (!item_valid || !item_stall)
            begin
                if (pending_beats.size() != 0 && gap_left == 0)
                begin
                    item       <= pending_beats.pop_front();
                    item_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                begin
                    item_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_frames.size() == 0)
                    report_mismatch($sformatf("unexpected result beat, frame %0d",
                                              result.frame_index));
                else
                begin
                    want_frame = expected_frames.pop_front();
                    if (result.frame_index !== want_frame.frame_index)
                        report_mismatch($sformatf("frame_index %0d, predicted %0d",
                                                  result.frame_index, want_frame.frame_index));
                    if (result.texture_out !== want_frame.texture_out)
                        report_mismatch($sformatf("texture_out %h, predicted %h",
                                                  result.texture_out, want_frame.texture_out));
                    if (result.changed !== want_frame.changed)
                        report_mismatch($sformatf("changed %b, predicted %b",
                                                  result.changed, want_frame.changed));
                    if (want_frame.changed)
                        frames_moved++;
                end
            end
            if (mode_left == 0)
            begin
                mode_left  = $urandom_range(20, 200);
                stall_mode = $urandom_range(0, 3);
            end
            mode_left--;
            stall_tick++;
            case (stall_mode)
                0:       result_stall <= 1'b0;
                1:       result_stall <= ($urandom_range(0, 3) == 0);
                2:       result_stall <= ($urandom_range(0, 3) != 0);
                default: result_stall <= stall_tick[0];
            endcase
        end
    end

    task automatic apb_write(input aft_pkg::reg_idx_t idx,
                             input logic [aft_pkg::PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_timer(input bit en, input int total);
        apb_write(aft_pkg::REG_ENABLE, aft_pkg::PDATA_W'(en));
        cfg_enable = en;
        apb_write(aft_pkg::REG_FRAME_TOTAL, aft_pkg::PDATA_W'(total));
        cfg_total = total;
        settings_used++;
    endtask

    task automatic drain();
        while (pending_beats.size() != 0 || item_valid || expected_frames.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_load(input int idx, input logic [aft_pkg::DELAY_W-1:0] hold_ms,
                              input logic [aft_pkg::TEX_W-1:0] tex);
        aft_pkg::item_t beat;
        beat.func           = aft_pkg::FUNC_LOAD;
        beat.entry_index    = aft_pkg::IDX_W'(idx);
        beat.entry_delay_ms = hold_ms;
        beat.entry_texture  = tex;
        beat.now_ms         = aft_pkg::TIME_W'($urandom);
        loaded[idx]         = 1'b1;
        pending_beats.push_back(beat);
    endtask

    task automatic queue_tick(input logic [aft_pkg::TIME_W-1:0] now);
        aft_pkg::item_t beat;
        beat.func           = aft_pkg::FUNC_TICK;
        beat.entry_index    = aft_pkg::IDX_W'($urandom);
        beat.entry_delay_ms = aft_pkg::DELAY_W'($urandom);
        beat.entry_texture  = aft_pkg::TEX_W'($urandom);
        beat.now_ms         = now;
        pending_beats.push_back(beat);
    endtask

    function automatic logic [aft_pkg::DELAY_W-1:0] random_delay();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return aft_pkg::DELAY_W'($urandom_range(0, 40));
        if (pick < 9)
            return aft_pkg::DELAY_W'($urandom_range(0, 2000));
        return aft_pkg::DELAY_W'($urandom);
    endfunction

    function automatic logic [aft_pkg::TIME_W-1:0] next_time();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 13)
            gen_now = gen_now + aft_pkg::TIME_W'($urandom_range(0, 40));
        else if (pick < 15)
            gen_now = gen_now + aft_pkg::TIME_W'($urandom_range(0, 5000));
        else if (pick < 16)
            gen_now = gen_now + aft_pkg::TIME_W'($urandom_range(0, 2_000_000));
        else if (pick < 17)
            gen_now = aft_pkg::TIME_W'($urandom);
        else if (pick < 19)
            gen_now = gen_now - aft_pkg::TIME_W'($urandom_range(1, 100));
        return gen_now;
    endfunction

    task automatic run_phase(input bit en, input int total, input int n_items);
        int count;
        int done;
        int chunk;
        int idx;
        drain();
        program_timer(en, total);
        count = (total > FRAME_SLOTS) ? FRAME_SLOTS : total;
        if (en && count > 1)
            for (int k = 0; k < count; k++)
                if (!loaded[k])
                    queue_load(k, random_delay(), aft_pkg::TEX_W'($urandom));
        done = 0;
        while (done < n_items)
        begin
            chunk = $urandom_range(1, 40);
            if (chunk > n_items - done)
                chunk = n_items - done;
            repeat (chunk)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    if (count > 0 && $urandom_range(0, 9) < 7)
                        idx = $urandom_range(0, count - 1);
                    else
                        idx = $urandom_range(0, FRAME_SLOTS - 1);
                    queue_load(idx, random_delay(), aft_pkg::TEX_W'($urandom));
                end
                else
                    queue_tick(next_time());
            end
            done += chunk;
            if ($urandom_range(0, 3) == 0)
                drain();
        end
    endtask

    initial
    begin
        for (int k = 0; k < FRAME_SLOTS; k++)
            loaded[k] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_load(0, '0, '0);
        queue_load(255, '1, '1);
        queue_load(1, aft_pkg::DELAY_W'(9), 32'hA5A5_0001);
        queue_load(2, aft_pkg::DELAY_W'(10), 32'h5A5A_0002);
        queue_tick('0);
        queue_tick('1);
        drain();
        program_timer(1'b1, 0);
        queue_tick(32'd500);
        drain();
        program_timer(1'b1, 1);
        queue_tick(32'd500);
        drain();
        program_timer(1'b1, 3);
        queue_tick(32'd100);
        queue_tick(32'd105);
        queue_tick(32'd110);
        queue_tick(32'd119);
        queue_tick(32'd120);
        drain();
        program_timer(1'b1, 2);
        queue_tick(32'd125);
        queue_load(3, aft_pkg::DELAY_W'(1000), 32'h0F0F_0003);
        queue_tick(32'd60);
        queue_tick(32'd1060);
        queue_tick('1);
        queue_tick('1);
        queue_tick('0);
        gen_now = '0;

        run_phase(1'b1, 2, 90);
        run_phase(1'b1, 5, 110);
        run_phase(1'b0, 5, 30);
        run_phase(1'b1, 16, 110);
        run_phase(1'b1, 256, 40);
        run_phase(1'b1, 3, 70);
        run_phase(1'b1, 511, 40);
        run_phase(1'b1, 0, 20);
        run_phase(1'b1, 40, 110);
        run_phase(1'b1, 1, 20);
        run_phase(1'b1, 7, 90);

        drain();
        repeat (600) @(posedge clk);

        $display("Ran %0d load and %0d tick beats across %0d timer settings",
                 load_beats, tick_beats, settings_used);
        $display("%0d ticks moved the frame, %0d of them skipping whole loops",
                 frames_moved, loop_skips);
        if (fail_count == 0)
            $display("animation_frame_timer test passed");
        else
            $display("animation_frame_timer test failed");
        $finish;
    end

endmodule
